[sv/packed_ring_desc_prefetch_core_macros.svh]
// assertion macros shared by the prefetch core modules
// each expects i_clk and i_rst_n in scope
`ifndef PACKED_RING_DESC_PREFETCH_CORE_MACROS_SVH
`define PACKED_RING_DESC_PREFETCH_CORE_MACROS_SVH

// condition must hold in the same cycle
`define PRDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the following cycle
`define PRDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/prdp_pkg.sv]
package prdp_pkg;

    // descriptor and copy geometry
    localparam int DESC_BYTES     = 16;
    localparam int DESC_LOG2      = $clog2(DESC_BYTES);
    localparam int DMA_ALIGN_LOG2 = 6;
    localparam int DMA_ALIGN      = 1 << DMA_ALIGN_LOG2;
    localparam int OFF_W          = 12;
    localparam logic [OFF_W-1:0] ALIGN_MASK = OFF_W'(DMA_ALIGN - 1);

    // field widths
    localparam int ADDR_W     = 64;
    localparam int IDX_W      = 16;
    localparam int FLAGS_W    = 16;
    localparam int LOG2_W     = 4;
    localparam int WIN_W      = 9;
    localparam int LEN_W      = 20;
    localparam int SLOT_W     = 15;
    localparam int CNT1_W     = 16;
    localparam int OFFSET_W   = SLOT_W + DESC_LOG2;
    localparam int CFG_IDX_W  = 2;

    // descriptor flag bits
    localparam int FLAG_NEXT_BIT     = 0;
    localparam int FLAG_INDIRECT_BIT = 2;
    localparam int FLAG_AVAIL_BIT    = 7;
    localparam int FLAG_USED_BIT     = 15;

    // reset values of the configuration
    localparam logic [LOG2_W-1:0] RING_LOG2_RESET = LOG2_W'(8);
    localparam logic [WIN_W-1:0]  WINDOW_RESET    = WIN_W'(32);

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        REQ_KICK  = 1'b0,
        REQ_FLAGS = 1'b1
    } t_req;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_DMA    = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_DMA_REQ     = 3'd0,
        ST_BUSY        = 3'd1,
        ST_ACCEPTED    = 3'd2,
        ST_NOT_AVAIL   = 3'd3,
        ST_RING_FULL   = 3'd4,
        ST_WINDOW_DONE = 3'd5,
        ST_IDLE        = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOST_BASE   = 2'd0,
        CFG_LOCAL_BASE  = 2'd1,
        CFG_RING_LOG2   = 2'd2,
        CFG_WINDOW_SIZE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_req               req_type;
        logic [FLAGS_W-1:0] desc_flags;
        logic [IDX_W-1:0]   consumed_index;
    } t_in_word;

    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [ADDR_W-1:0]  dma_src;
        logic [ADDR_W-1:0]  dma_dst;
        logic [LEN_W-1:0]   dma_len;
        logic [IDX_W-1:0]   next_index;
        logic               wrap_counter;
        logic [IDX_W-1:0]   chain_end_index;
        logic [IDX_W-1:0]   indirect_count;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [ADDR_W-1:0] host_base;
        logic [ADDR_W-1:0] local_base;
        logic [LOG2_W-1:0] ring_log2;
        logic [WIN_W-1:0]  window_size;
    } t_cfg;

    // one planned item: optional status word, then zero to two copies
    typedef struct packed {
        logic                has_status;
        t_status             status;
        logic [IDX_W-1:0]    next_index;
        logic                wrap;
        logic [IDX_W-1:0]    chain_end;
        logic [IDX_W-1:0]    indir;
        logic                has_dma;
        logic                split;
        logic [CNT1_W-1:0]   cnt1;
        logic [WIN_W-1:0]    cnt2;
        logic [OFFSET_W-1:0] offset;
    } t_cmd;

endpackage

[sv/prdp_front.sv]
module prdp_front import prdp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [IDX_W-1:0] r_next_desc,   n_next_desc;
    logic             r_avail_wrap,  n_avail_wrap;
    logic             r_fetching,    n_fetching;
    logic [IDX_W-1:0] r_scan_index,  n_scan_index;
    logic             r_scan_wrap,   n_scan_wrap;
    logic [IDX_W-1:0] r_window_end,  n_window_end;
    logic [IDX_W-1:0] r_chain_end,   n_chain_end;
    logic [IDX_W-1:0] r_indir_seen,  n_indir_seen;

    logic [LOG2_W-1:0] ring_log2;
    logic [IDX_W-1:0]  ring_n;
    logic [IDX_W-1:0]  ring_mask;
    logic [WIN_W-1:0]  win_nz;
    logic [WIN_W-1:0]  win;

    logic [IDX_W-1:0]  si_inc;
    logic [IDX_W-1:0]  indir_inc;
    logic [IDX_W-1:0]  chain_upd;
    logic              sw_upd;
    logic [IDX_W-1:0]  gap;
    logic              avail_bit;
    logic              used_bit;
    logic              do_kick;
    logic [IDX_W-1:0]  kick_idx;
    logic              kick_wrap;
    logic [IDX_W-1:0]  slot;
    logic [IDX_W:0]    slot_end;
    logic              split;

    // ring and window size, clamped
    always_comb begin
        ring_log2 = (i_cfg.ring_log2 == '0) ? LOG2_W'(1) : i_cfg.ring_log2;
        ring_n    = IDX_W'(1) << ring_log2;
        ring_mask = ring_n - IDX_W'(1);
        win_nz    = (i_cfg.window_size == '0) ? WIN_W'(1) : i_cfg.window_size;
        win       = ({{(IDX_W-WIN_W){1'b0}}, win_nz} > ring_n) ? ring_n[WIN_W-1:0] : win_nz;
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // classify the word and plan its results
    always_comb begin
        n_next_desc  = r_next_desc;
        n_avail_wrap = r_avail_wrap;
        n_fetching   = r_fetching;
        n_scan_index = r_scan_index;
        n_scan_wrap  = r_scan_wrap;
        n_window_end = r_window_end;
        n_chain_end  = r_chain_end;
        n_indir_seen = r_indir_seen;

        si_inc    = r_scan_index + IDX_W'(1);
        indir_inc = r_indir_seen + IDX_W'(i_in_data.desc_flags[FLAG_INDIRECT_BIT]);
        chain_upd = i_in_data.desc_flags[FLAG_NEXT_BIT] ? r_chain_end : si_inc;
        sw_upd    = r_scan_wrap ^ ((si_inc & ring_mask) == '0);
        gap       = r_scan_index - i_in_data.consumed_index;
        avail_bit = i_in_data.desc_flags[FLAG_AVAIL_BIT];
        used_bit  = i_in_data.desc_flags[FLAG_USED_BIT];

        do_kick   = 1'b0;
        kick_idx  = r_next_desc;
        kick_wrap = r_avail_wrap;

        o_cmd            = '0;
        o_cmd.has_status = 1'b1;
        o_cmd.status     = ST_BUSY;
        o_cmd.next_index = r_next_desc;
        o_cmd.wrap       = r_avail_wrap;
        o_cmd.chain_end  = r_chain_end;
        o_cmd.indir      = r_indir_seen;

        case (i_in_data.req_type)
            REQ_KICK: begin
                if (r_fetching) begin
                    o_cmd.status = ST_BUSY;
                end else begin
                    do_kick          = 1'b1;
                    o_cmd.has_status = 1'b0;
                end
            end
            REQ_FLAGS: begin
                if (!r_fetching) begin
                    o_cmd.status = ST_IDLE;
                end else if (gap == ring_n || avail_bit != r_scan_wrap
                             || used_bit == r_scan_wrap) begin
                    // stop: commit the scan position and close the window
                    n_next_desc      = r_scan_index;
                    n_avail_wrap     = r_scan_wrap;
                    n_fetching       = 1'b0;
                    o_cmd.status     = (gap == ring_n) ? ST_RING_FULL : ST_NOT_AVAIL;
                    o_cmd.next_index = r_scan_index;
                    o_cmd.wrap       = r_scan_wrap;
                end else if (si_inc == r_window_end) begin
                    // window complete: commit and open the next one
                    n_next_desc      = si_inc;
                    n_avail_wrap     = sw_upd;
                    n_chain_end      = chain_upd;
                    do_kick          = 1'b1;
                    kick_idx         = si_inc;
                    kick_wrap        = sw_upd;
                    o_cmd.status     = ST_WINDOW_DONE;
                    o_cmd.next_index = si_inc;
                    o_cmd.wrap       = sw_upd;
                    o_cmd.chain_end  = chain_upd;
                    o_cmd.indir      = indir_inc;
                end else begin
                    n_scan_index    = si_inc;
                    n_scan_wrap     = sw_upd;
                    n_chain_end     = chain_upd;
                    n_indir_seen    = indir_inc;
                    o_cmd.status    = ST_ACCEPTED;
                    o_cmd.wrap      = sw_upd;
                    o_cmd.chain_end = chain_upd;
                    o_cmd.indir     = indir_inc;
                end
            end
            default: begin
                o_cmd.status = ST_BUSY;
            end
        endcase

        // window opening and copy split
        slot     = kick_idx & ring_mask;
        slot_end = {1'b0, slot} + (IDX_W+1)'(win);
        split    = slot_end > {1'b0, ring_n};
        if (do_kick) begin
            n_scan_index  = kick_idx;
            n_scan_wrap   = kick_wrap;
            n_window_end  = kick_idx + IDX_W'(win);
            n_indir_seen  = '0;
            n_fetching    = 1'b1;
            o_cmd.has_dma = 1'b1;
            o_cmd.split   = split;
            o_cmd.cnt1    = split ? (ring_n - slot) : CNT1_W'(win);
            o_cmd.cnt2    = slot_end[WIN_W-1:0] - ring_n[WIN_W-1:0];
            o_cmd.offset  = {slot[SLOT_W-1:0], {DESC_LOG2{1'b0}}};
        end
    end

    // ring state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_desc  <= '0;
            r_avail_wrap <= 1'b1;
            r_fetching   <= 1'b0;
            r_scan_index <= '0;
            r_scan_wrap  <= 1'b0;
            r_window_end <= '0;
            r_chain_end  <= '0;
            r_indir_seen <= '0;
        end else if (o_push) begin
            r_next_desc  <= n_next_desc;
            r_avail_wrap <= n_avail_wrap;
            r_fetching   <= n_fetching;
            r_scan_index <= n_scan_index;
            r_scan_wrap  <= n_scan_wrap;
            r_window_end <= n_window_end;
            r_chain_end  <= n_chain_end;
            r_indir_seen <= n_indir_seen;
        end
    end

endmodule

[sv/prdp_queue.sv]
`include "packed_ring_desc_prefetch_core_macros.svh"

module prdp_queue import prdp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `PRDP_ASSERT_NOW(a_no_overflow, i_push, !o_full || i_pop, "push into full queue")
    `PRDP_ASSERT_NOW(a_no_underflow, i_pop, o_valid, "pop from empty queue")
    `PRDP_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count slip")

endmodule

[sv/prdp_back.sv]
`include "packed_ring_desc_prefetch_core_macros.svh"

module prdp_back import prdp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_cmd      i_q_data,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic [1:0]        r_sub;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [1:0]        res_cnt;
    logic              is_last;
    logic              load;
    logic              dma_second;
    logic [ADDR_W-1:0] sum_h;
    logic [OFF_W-1:0]  off;
    t_out_word         word;

    // results of the head entry
    assign res_cnt = 2'(i_q_data.has_status)
                   + (i_q_data.has_dma ? (i_q_data.split ? 2'd2 : 2'd1) : 2'd0);
    assign is_last = (r_sub == res_cnt - 2'd1);
    assign load    = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop = load && is_last;

    // copy address of the first copy, aligned down
    assign sum_h = i_cfg.host_base + ADDR_W'(i_q_data.offset);
    assign off   = sum_h[OFF_W-1:0] & ALIGN_MASK;

    // build the next result word
    always_comb begin
        dma_second = (r_sub != 2'(i_q_data.has_status));
        word                 = '0;
        word.next_index      = i_q_data.next_index;
        word.wrap_counter    = i_q_data.wrap;
        word.chain_end_index = i_q_data.chain_end;
        word.last            = is_last;
        if (i_q_data.has_status && r_sub == 2'd0) begin
            word.kind           = KIND_STATUS;
            word.status         = i_q_data.status;
            word.indirect_count = i_q_data.indir;
        end else begin
            word.kind   = KIND_DMA;
            word.status = ST_DMA_REQ;
            if (dma_second) begin
                word.dma_src = i_cfg.host_base;
                word.dma_dst = i_cfg.local_base;
                word.dma_len = LEN_W'({i_q_data.cnt2, {DESC_LOG2{1'b0}}});
            end else begin
                word.dma_src = sum_h & {{(ADDR_W-OFF_W){1'b1}}, ~ALIGN_MASK};
                word.dma_dst = i_cfg.local_base + ADDR_W'(i_q_data.offset) - ADDR_W'(off);
                word.dma_len = LEN_W'({i_q_data.cnt1, {DESC_LOG2{1'b0}}}) + LEN_W'(off);
            end
        end
    end

    // output register and position in the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_sub       <= is_last ? 2'd0 : r_sub + 2'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PRDP_ASSERT_NOW(a_entry_nonempty, i_q_valid, res_cnt != 2'd0, "entry without results")
    `PRDP_ASSERT_NOW(a_sub_in_range, i_q_valid, r_sub < res_cnt, "result position past entry")
    `PRDP_ASSERT_NEXT(a_sub_idle, !i_q_valid, r_sub == $past(r_sub), "position moved while empty")

endmodule

[sv/packed_ring_desc_prefetch_core.sv]
// channel  | dir | handshake                  | word
// ---------+-----+----------------------------+--------------------------------
// in       | in  | i_in_valid / o_in_ready    | t_in_word: kick or flags word
// out      | out | o_out_valid / i_out_ready  | t_out_word: status or copy plan
// cfg      | in  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one input word is taken per cycle while the four-entry command queue has room
// each word yields one to three result words, sent one per cycle from the output register while i_out_ready is high
// first result passes through the command queue entry and then the output register
// reset is synchronous and active low; there is no clearing pass
// a stalled output backs up the queue, then drops o_in_ready; cfg is always ready
module packed_ring_desc_prefetch_core import prdp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data
);

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    t_cmd q_in;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.host_base   <= '0;
            r_cfg.local_base  <= '0;
            r_cfg.ring_log2   <= RING_LOG2_RESET;
            r_cfg.window_size <= WINDOW_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HOST_BASE:   r_cfg.host_base   <= i_cfg_data;
                CFG_LOCAL_BASE:  r_cfg.local_base  <= i_cfg_data;
                CFG_RING_LOG2:   r_cfg.ring_log2   <= i_cfg_data[LOG2_W-1:0];
                CFG_WINDOW_SIZE: r_cfg.window_size <= i_cfg_data[WIN_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front: ring state and planning
    prdp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    prdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    // back: result expansion and copy addresses
    prdp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
